@@ design/rsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rsc_pkg: shared types and helpers of the record sort/collapse unit
// Record layout, queue entry, sort key selection.
// ----------------------------------------------------------------------------
package rsc_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int QDEPTH   = 2;

   localparam logic [2:0] MODE_BC      = 3'd0;
   localparam logic [2:0] MODE_UMI     = 3'd1;
   localparam logic [2:0] MODE_FPE     = 3'd2;
   localparam logic [2:0] MODE_CNT     = 3'd3;
   localparam logic [2:0] MODE_FPB     = 3'd4;

   typedef struct packed {
      logic [63:0] barcode;
      logic [63:0] umi;
      logic [31:0] eq_class;
      logic [31:0] count;
      logic [31:0] flags;
      logic [31:0] pad;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      rec_type rec;
      logic    store;    // record goes into the store
      logic    close;    // batch ends with this beat
      logic    dropped;  // some record of the batch was dropped
   } qent_type;

   function automatic logic [REC_W-1:0] sort_key(input rec_type r, input logic [2:0] mode);
      logic [REC_W-1:0] k;
      unique case (mode)
         MODE_UMI: k = {r.umi, r.barcode, r.eq_class, r.flags, r.pad, r.count};
         MODE_FPE: k = {r.flags, r.pad, r.eq_class, r.barcode, r.umi, r.count};
         MODE_CNT: k = {r.count, r.barcode, r.umi, r.eq_class, r.flags, r.pad};
         MODE_FPB: k = {r.flags, r.pad, r.barcode, r.umi, r.eq_class, r.count};
         default:  k = {r.barcode, r.umi, r.eq_class, r.flags, r.pad, r.count};
      endcase
      return k;
   endfunction

   function automatic logic same_keys(input rec_type a, input rec_type b);
      return a.barcode == b.barcode && a.umi == b.umi && a.eq_class == b.eq_class &&
             a.flags == b.flags && a.pad == b.pad;
   endfunction

endpackage

@@ design/rsc_ram.sv @@
// ----------------------------------------------------------------------------
// rsc_ram: generic single-write, single-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module rsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            we,
   input  logic [$clog2(DEPTH)-1:0]        waddr,
   input  logic [WIDTH-1:0]                wdata,
   input  logic [$clog2(DEPTH)-1:0]        raddr,
   output logic [WIDTH-1:0]                rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/rsc_front.sv @@
// ----------------------------------------------------------------------------
// rsc_front: intake and classification
// Tracks batch fill, marks drops, queues store/close beats for the back end.
// ----------------------------------------------------------------------------
module rsc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  rsc_pkg::rec_type  in_rec,
   input  logic              in_last,
   output logic              q_valid,
   output rsc_pkg::qent_type q_head,
   input  logic              q_pop
);

   localparam int QW = $clog2(rsc_pkg::QDEPTH + 1);
   localparam int QA = $clog2(rsc_pkg::QDEPTH);

   rsc_pkg::qent_type         q_ff [rsc_pkg::QDEPTH];
   logic [QA-1:0]             wp_ff, wp_in, rp_ff, rp_in;
   logic [QW-1:0]             lvl_ff, lvl_in;
   logic [rsc_pkg::CNT_W-1:0] fill_ff, fill_in;
   logic                      drop_ff, drop_in;
   logic                      acc, has_room, push;
   rsc_pkg::qent_type         ent;

   assign in_stall = (lvl_ff == QW'(rsc_pkg::QDEPTH));
   assign acc      = in_valid && !in_stall;
   assign has_room = (fill_ff < rsc_pkg::CNT_W'(rsc_pkg::CAPACITY));

   always_comb begin
      ent.rec     = in_rec;
      ent.store   = has_room;
      ent.close   = in_last;
      ent.dropped = drop_ff || !has_room;
      push        = acc && (has_room || in_last);
      fill_in     = fill_ff;
      drop_in     = drop_ff;
      if (acc) begin
         if (in_last) begin
            fill_in = '0;
            drop_in = 1'b0;
         end else if (has_room) begin
            fill_in = fill_ff + 1'b1;
         end else begin
            drop_in = 1'b1;
         end
      end
      wp_in  = push  ? QA'((32'(wp_ff) + 1) % rsc_pkg::QDEPTH) : wp_ff;
      rp_in  = q_pop ? QA'((32'(rp_ff) + 1) % rsc_pkg::QDEPTH) : rp_ff;
      lvl_in = lvl_ff + QW'(push) - QW'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         lvl_ff  <= '0;
         fill_ff <= '0;
         drop_ff <= 1'b0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         lvl_ff  <= lvl_in;
         fill_ff <= fill_in;
         drop_ff <= drop_in;
      end
      if (push) begin
         q_ff[wp_ff] <= ent;
      end
   end

   assign q_valid = (lvl_ff != '0);
   assign q_head  = q_ff[rp_ff];

endmodule

@@ design/rsc_back.sv @@
// ----------------------------------------------------------------------------
// rsc_back: store, selection sort and duplicate merge
// Each output pick is one scan over the store for the smallest unpicked record.
// ----------------------------------------------------------------------------
module rsc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        mode,
   input  logic              q_valid,
   input  rsc_pkg::qent_type q_head,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_stall,
   output rsc_pkg::rec_type  out_rec,
   output logic              out_last,
   output logic              out_ovf
);

   localparam int AW = rsc_pkg::ADDR_W;
   localparam int CW = rsc_pkg::CNT_W;

   typedef enum logic [1:0] {S_LOAD, S_SCAN, S_PICK, S_LAST} state_type;

   state_type          state_ff;
   logic [CW-1:0]      n_ff, rem_ff, sc_ff;
   logic               rv_ff, have_best_ff, have_pend_ff, ovf_ff;
   logic [AW-1:0]      rtag_ff, best_idx_ff;
   rsc_pkg::rec_type   best_ff, pend_ff;
   logic [rsc_pkg::CAPACITY-1:0] done_ff;
   logic               ov_ff, olast_ff, oovf_ff;
   rsc_pkg::rec_type   orec_ff;

   logic               we, out_free, better, emit;
   logic [AW-1:0]      waddr, raddr;
   logic [rsc_pkg::REC_W-1:0] rdata;
   rsc_pkg::rec_type   rrec;

   assign out_free = !ov_ff || !out_stall;
   assign q_pop    = (state_ff == S_LOAD) && q_valid;
   assign we       = q_pop && q_head.store;
   assign waddr    = n_ff[AW-1:0];
   assign raddr    = sc_ff[AW-1:0];
   assign rrec     = rsc_pkg::rec_type'(rdata);
   assign better   = rv_ff && !done_ff[rtag_ff] &&
                     (!have_best_ff || rsc_pkg::sort_key(rrec, mode) <
                                       rsc_pkg::sort_key(best_ff, mode));
   // a new beat is loaded into the output register this cycle
   assign emit     = out_free &&
                     ((state_ff == S_PICK && have_pend_ff &&
                       !rsc_pkg::same_keys(pend_ff, best_ff)) ||
                      state_ff == S_LAST);

   rsc_ram #(.WIDTH(rsc_pkg::REC_W), .DEPTH(rsc_pkg::CAPACITY)) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (q_head.rec),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         n_ff         <= '0;
         rem_ff       <= '0;
         sc_ff        <= '0;
         rv_ff        <= 1'b0;
         have_best_ff <= 1'b0;
         have_pend_ff <= 1'b0;
         ov_ff        <= 1'b0;
         done_ff      <= '0;
      end else begin
         if (emit) begin
            ov_ff <= 1'b1;
         end else if (!out_stall) begin
            ov_ff <= 1'b0;
         end
         unique case (state_ff)
            S_LOAD: begin
               if (q_pop) begin
                  if (q_head.store) begin
                     done_ff[waddr] <= 1'b0;
                  end
                  if (q_head.close) begin
                     rem_ff       <= n_ff + CW'(q_head.store);
                     n_ff         <= n_ff + CW'(q_head.store);
                     ovf_ff       <= q_head.dropped;
                     sc_ff        <= '0;
                     have_best_ff <= 1'b0;
                     have_pend_ff <= 1'b0;
                     state_ff     <= S_SCAN;
                  end else begin
                     n_ff <= n_ff + 1'b1;
                  end
               end
            end
            S_SCAN: begin
               rv_ff   <= (sc_ff < n_ff);
               rtag_ff <= sc_ff[AW-1:0];
               if (sc_ff < n_ff) begin
                  sc_ff <= sc_ff + 1'b1;
               end
               if (better) begin
                  best_ff      <= rrec;
                  best_idx_ff  <= rtag_ff;
                  have_best_ff <= 1'b1;
               end
               if (sc_ff == n_ff && !rv_ff) begin
                  state_ff <= S_PICK;
               end
            end
            S_PICK: begin
               if (!have_pend_ff || rsc_pkg::same_keys(pend_ff, best_ff) || out_free) begin
                  if (have_pend_ff && rsc_pkg::same_keys(pend_ff, best_ff)) begin
                     pend_ff.count <= pend_ff.count + best_ff.count;
                  end else begin
                     if (have_pend_ff) begin
                        orec_ff  <= pend_ff;
                        olast_ff <= 1'b0;
                        oovf_ff  <= ovf_ff;
                     end
                     pend_ff <= best_ff;
                  end
                  have_pend_ff         <= 1'b1;
                  done_ff[best_idx_ff] <= 1'b1;
                  rem_ff               <= rem_ff - 1'b1;
                  sc_ff                <= '0;
                  have_best_ff         <= 1'b0;
                  state_ff             <= (rem_ff == CW'(1)) ? S_LAST : S_SCAN;
               end
            end
            S_LAST: begin
               if (out_free) begin
                  orec_ff      <= pend_ff;
                  olast_ff     <= 1'b1;
                  oovf_ff      <= ovf_ff;
                  have_pend_ff <= 1'b0;
                  n_ff         <= '0;
                  state_ff     <= S_LOAD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign out_valid = ov_ff;
   assign out_rec   = orec_ff;
   assign out_last  = olast_ff;
   assign out_ovf   = oovf_ff;

endmodule

@@ design/record_sort_collapse_unit.sv @@
// ----------------------------------------------------------------------------
// record_sort_collapse_unit: batch record sort with duplicate merge
// Loads a batch, sorts under the selected key order, merges equal-key runs.
// ----------------------------------------------------------------------------
//   channel | ports      | direction | beat
//   req     | req_*      | in        | one record, req_last_in closes batch
//   rsp     | rsp_*      | out       | one merged record, in sorted order
//   csr     | psel/...   | in/out    | sort_mode at address 0
//
// Records load one per cycle through a two-entry queue while req_stall is low.
// After the closing beat, each stored record takes one result pick, and each
// pick scans the store once through the store RAM's single read port.
// Reset is synchronous; it empties the queue and the batch.
// A stalled rsp holds its beat; the sorter waits on it only when emitting.
module record_sort_collapse_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_barcode,
   input  logic [63:0] req_umi,
   input  logic [31:0] req_eq_class,
   input  logic [31:0] req_rec_count,
   input  logic [31:0] req_flag_bits,
   input  logic [31:0] req_pad_word,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_barcode,
   output logic [63:0] rsp_out_umi,
   output logic [31:0] rsp_out_eq_class,
   output logic [31:0] rsp_out_count,
   output logic [31:0] rsp_out_flags,
   output logic [31:0] rsp_out_pad,
   output logic        rsp_last_out,
   output logic        rsp_overflow,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [0:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [2:0]        mode_ff;
   rsc_pkg::rec_type  in_rec, out_rec;
   rsc_pkg::qent_type q_head;
   logic              q_valid, q_pop;

   assign pready = 1'b1;
   assign prdata = (paddr == 1'b0) ? {29'd0, mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rsc_pkg::MODE_BC;
      end else if (psel && penable && pwrite && paddr == 1'b0) begin
         mode_ff <= pwdata[2:0];
      end
   end

   always_comb begin
      in_rec.barcode  = req_barcode;
      in_rec.umi      = req_umi;
      in_rec.eq_class = req_eq_class;
      in_rec.count    = req_rec_count;
      in_rec.flags    = req_flag_bits;
      in_rec.pad      = req_pad_word;
   end

   rsc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_rec   (in_rec),
      .in_last  (req_last_in),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   rsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_rec   (out_rec),
      .out_last  (rsp_last_out),
      .out_ovf   (rsp_overflow)
   );

   assign rsp_out_barcode  = out_rec.barcode;
   assign rsp_out_umi      = out_rec.umi;
   assign rsp_out_eq_class = out_rec.eq_class;
   assign rsp_out_count    = out_rec.count;
   assign rsp_out_flags    = out_rec.flags;
   assign rsp_out_pad      = out_rec.pad;

endmodule

@@ design/rsc_checker.sv @@
// ----------------------------------------------------------------------------
// rsc_checker: port-level checks of the record sort/collapse unit
// Attached to the top level by bind.
// ----------------------------------------------------------------------------
module rsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_out_count,
   input logic        rsp_last_out,
   input logic [31:0] prdata,
   input logic        pready
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_count) && $stable(rsp_last_out))
      else $error("stalled rsp beat changed");

   a_ready: assert property (@(posedge clock) pready)
      else $error("pready low");

   a_mode_width: assert property (@(posedge clock) prdata[31:3] == 29'd0)
      else $error("csr readback has stray bits");

endmodule

bind record_sort_collapse_unit rsc_checker u_rsc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_count (rsp_out_count),
   .rsp_last_out  (rsp_last_out),
   .prdata        (prdata),
   .pready        (pready)
);

@@ tb/record_sort_collapse_unit_tb.sv @@
// ----------------------------------------------------------------------------
// record_sort_collapse_unit_tb: self-checking bench for the record sort unit
// Drives record batches under every sort mode and checks each merged record
// against an in-bench sorter/merger, with random gaps and stalls.
// ----------------------------------------------------------------------------
module record_sort_collapse_unit_tb;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int MAX_GAP        = 12;
   localparam int DEPTH          = 64;

   typedef struct packed {
      logic [63:0] barcode;
      logic [63:0] umi;
      logic [31:0] eq_class;
      logic [31:0] count;
      logic [31:0] flags;
      logic [31:0] pad;
      logic        last;
      logic        ovf;
   } merged_type;

   typedef struct {
      rsc_pkg::rec_type rec;
      logic             last;
      bit               has_exp;
      merged_type       exp;
   } stim_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [63:0] req_barcode = '0;
   logic [63:0] req_umi = '0;
   logic [31:0] req_eq_class = '0;
   logic [31:0] req_rec_count = '0;
   logic [31:0] req_flag_bits = '0;
   logic [31:0] req_pad_word = '0;
   logic        req_last_in = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [63:0] rsp_out_barcode;
   logic [63:0] rsp_out_umi;
   logic [31:0] rsp_out_eq_class;
   logic [31:0] rsp_out_count;
   logic [31:0] rsp_out_flags;
   logic [31:0] rsp_out_pad;
   logic        rsp_last_out;
   logic        rsp_overflow;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [0:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   record_sort_collapse_unit dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // predictor state
   rsc_pkg::rec_type batch_store[DEPTH];
   int               batch_fill = 0;
   bit               batch_dropped = 0;
   logic [2:0]       key_mode = rsc_pkg::MODE_BC;

   merged_type pending_records[$];
   int         mismatches = 0;
   int         idle_cycles = 0;
   bit         quiet = 0;
   int         stall_left = 0;

   function automatic logic [rsc_pkg::REC_W-1:0] order_key(rsc_pkg::rec_type r,
                                                           logic [2:0] m);
      case (m)
         rsc_pkg::MODE_UMI: return {r.umi, r.barcode, r.eq_class, r.flags, r.pad, r.count};
         rsc_pkg::MODE_FPE: return {r.flags, r.pad, r.eq_class, r.barcode, r.umi, r.count};
         rsc_pkg::MODE_CNT: return {r.count, r.barcode, r.umi, r.eq_class, r.flags, r.pad};
         rsc_pkg::MODE_FPB: return {r.flags, r.pad, r.barcode, r.umi, r.eq_class, r.count};
         default:           return {r.barcode, r.umi, r.eq_class, r.flags, r.pad, r.count};
      endcase
   endfunction

   function automatic bit keys_match(rsc_pkg::rec_type a, rsc_pkg::rec_type b);
      return a.barcode == b.barcode && a.umi == b.umi && a.eq_class == b.eq_class
             && a.flags == b.flags && a.pad == b.pad;
   endfunction

   // store one record; on a closing beat sort, merge and queue the results
   function automatic int collapse_batch(rsc_pkg::rec_type r, logic last);
      rsc_pkg::rec_type x;
      merged_type       m;
      int               i, j, k, produced;
      logic [31:0]      sum;
      produced = 0;
      if (batch_fill < DEPTH) begin
         batch_store[batch_fill] = r;
         batch_fill++;
      end else
         batch_dropped = 1;
      if (!last) return 0;
      for (i = 1; i < batch_fill; i++) begin
         x = batch_store[i];
         j = i;
         while (j > 0 && order_key(x, key_mode) < order_key(batch_store[j-1], key_mode)) begin
            batch_store[j] = batch_store[j-1];
            j--;
         end
         batch_store[j] = x;
      end
      i = 0;
      while (i < batch_fill) begin
         sum = batch_store[i].count;
         k = i + 1;
         while (k < batch_fill && keys_match(batch_store[i], batch_store[k])) begin
            sum += batch_store[k].count;
            k++;
         end
         m.barcode  = batch_store[i].barcode;
         m.umi      = batch_store[i].umi;
         m.eq_class = batch_store[i].eq_class;
         m.count    = sum;
         m.flags    = batch_store[i].flags;
         m.pad      = batch_store[i].pad;
         m.last     = (k >= batch_fill);
         m.ovf      = batch_dropped;
         pending_records = {pending_records, m};
         produced++;
         i = k;
      end
      batch_fill = 0;
      batch_dropped = 0;
      return produced;
   endfunction

   function automatic void report(string what, merged_type e, merged_type a);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: exp bc=%h umi=%h ec=%h cnt=%h flg=%h pad=%h last=%b ovf=%b",
                  what, e.barcode, e.umi, e.eq_class, e.count, e.flags, e.pad,
                  e.last, e.ovf);
         $display("%s: got bc=%h umi=%h ec=%h cnt=%h flg=%h pad=%h last=%b ovf=%b",
                  what, a.barcode, a.umi, a.eq_class, a.count, a.flags, a.pad,
                  a.last, a.ovf);
      end
   endfunction

   function automatic int draw_wait();
      if (quiet || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   // result side: stall at random, check each accepted beat
   always @(posedge clock) begin
      merged_type got, want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_barcode, rsp_out_umi, rsp_out_eq_class, rsp_out_count,
                    rsp_out_flags, rsp_out_pad, rsp_last_out, rsp_overflow};
            if (pending_records.size() == 0)
               report("unexpected beat", got, got);
            else begin
               want = pending_records.pop_front();
               if (got !== want) report("mismatch", want, got);
            end
            stall_left = draw_wait();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else
            rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic write_mode(logic [2:0] m);
      @(posedge clock);
      psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= {29'd0, m}; penable <= 0;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      key_mode = m;
   endtask

   task automatic send_record(rsc_pkg::rec_type r, logic last, output int produced);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_barcode <= r.barcode; req_umi <= r.umi; req_eq_class <= r.eq_class;
      req_rec_count <= r.count; req_flag_bits <= r.flags; req_pad_word <= r.pad;
      req_last_in <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      produced = collapse_batch(r, last);
   endtask

   task automatic settle();
      req_valid <= 0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic rsc_pkg::rec_type random_record();
      rsc_pkg::rec_type r;
      r.barcode  = {$urandom, $urandom};
      r.umi      = {$urandom, $urandom};
      r.eq_class = $urandom;
      r.count    = $urandom;
      r.flags    = $urandom;
      r.pad      = $urandom;
      if ($urandom_range(0, 7) == 0) r.barcode = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 7) == 0) r.count = '1;
      if ($urandom_range(0, 3) == 0) r.flags = $urandom_range(0, 3);
      return r;
   endfunction

   // batch built from a small pool so equal keys meet often; counts differ
   task automatic random_batch(int len);
      rsc_pkg::rec_type pool[4];
      rsc_pkg::rec_type r;
      int               i, n;
      for (i = 0; i < 4; i++) pool[i] = random_record();
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 2) != 0) begin
            r = pool[$urandom_range(0, 3)];
            r.count = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
         end else
            r = random_record();
         send_record(r, i == len - 1, n);
      end
   endtask

   stim_row_type directed[$];

   function automatic void add_row(logic [63:0] bc, logic [63:0] umi, logic [31:0] ec,
                                   logic [31:0] cnt, logic [31:0] flg, logic [31:0] pad,
                                   logic last, bit chk, logic [31:0] exp_cnt);
      stim_row_type s;
      s.rec = '{bc, umi, ec, cnt, flg, pad};
      s.last = last;
      s.has_exp = chk;
      s.exp = '{bc, umi, ec, exp_cnt, flg, pad, 1'b1, 1'b0};
      directed = {directed, s};
   endfunction

   initial begin
      logic [2:0] modes[$];
      int n, p, b;
      merged_type m;

      modes = {rsc_pkg::MODE_UMI, rsc_pkg::MODE_FPE, rsc_pkg::MODE_CNT, rsc_pkg::MODE_FPB,
               3'd5, 3'd6, 3'd7, rsc_pkg::MODE_BC, rsc_pkg::MODE_CNT, rsc_pkg::MODE_FPE};

      // single-record batches at the extremes, a wrapping merge, a small sort
      add_row('0, '0, '0, '0, '0, '0, 1, 1, '0);
      add_row('1, '1, '1, '1, '1, '1, 1, 1, '1);
      add_row(64'h5, 64'h6, 7, 32'hFFFF_FFFF, 8, 9, 0, 0, 0);
      add_row(64'h5, 64'h6, 7, 32'h1, 8, 9, 1, 1, 32'h0);
      add_row(64'h30, 64'h1, 1, 3, 2, 0, 0, 0, 0);
      add_row(64'h10, 64'h9, 1, 4, 2, 0, 0, 0, 0);
      add_row(64'h10, 64'h2, 1, 5, 2, 0, 0, 0, 0);
      add_row(64'h10, 64'h2, 1, 6, 2, 0, 1, 0, 0);
      add_row(64'h8000_0000_0000_0000, 0, 32'h8000_0000, 2, 1, 1, 0, 0, 0);
      add_row(64'h7FFF_FFFF_FFFF_FFFF, '1, 32'h7FFF_FFFF, 1, 1, 1, 1, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (p = 0; p < directed.size(); p++) begin
         send_record(directed[p].rec, directed[p].last, n);
         if (directed[p].has_exp) begin
            m = pending_records[pending_records.size() - 1];
            if (n != 1 || m !== directed[p].exp) report("directed", directed[p].exp, m);
         end
      end
      settle();

      for (p = 0; p < modes.size(); p++) begin
         write_mode(modes[p]);
         quiet = (p % 3 == 1);
         // one phase runs a full store plus a dropped closing beat
         if (p == 2) random_batch(65);
         for (b = 0; b < 3; b++)
            random_batch($urandom_range(0, 3) == 0 ? 1 : $urandom_range(2, 8));
         settle();
      end
      quiet = 0;
      write_mode(rsc_pkg::MODE_FPB);
      random_batch(20);
      settle();

      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_records.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ files.f @@
design/rsc_pkg.sv
design/rsc_ram.sv
design/rsc_front.sv
design/rsc_back.sv
design/record_sort_collapse_unit.sv
design/rsc_checker.sv
tb/record_sort_collapse_unit_tb.sv
